// File: src/bdlp_pkg.sv
// shared types and constants for the button debouncer with long-press detection
// no dependencies

package bdlp_pkg;

   localparam int TIME_W      = 32;
   localparam int MS_W        = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [MS_W-1:0] DEBOUNCE_RST = 16'd20;
   localparam logic [MS_W-1:0] HOLD_RST     = 16'd1000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEBOUNCE = 2'd0,
      CSR_HOLD     = 2'd1,
      CSR_PRESENT  = 2'd2
   } csr_index_type;

   // per-button result of one sample
   typedef struct packed {
      logic changed;
      logic down;
      logic long_press;
   } btn_res_type;

endpackage

// File: src/button_debounce_long_press.sv
// top level of the multi-button debouncer with one-shot long press
// depends on bdlp_pkg, bdlp_button, bdlp_rsp_reg
//
// usage:
//   req channel: one transaction per sample, active-low pin levels per button
//   and a free-running millisecond time that wraps at 2^32
//   rsp channel: one transaction per sample with changed, down, pressed and
//   long-press masks plus an any-change flag
//   csr port: write debounce_ms (0), hold_ms (1), present_mask (2) while idle;
//   other indexes are ignored
// response: valid in the cycle after the request is accepted
// throughput: one sample per cycle while req_ready is high; all per-button
//   work is a single subtract and two compares, button state to result register
// stall: req_ready stays high while the result register is empty or being
//   drained; with a held result and rsp_ready low, req_ready drops
// reset: all button state clears, debounce_ms=20, hold_ms=1000, present
//   mask 3'b111 (all buttons at BUTTON_COUNT=3); no response is pending

module button_debounce_long_press
   import bdlp_pkg::*;
#(
   parameter int BUTTON_COUNT = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [BUTTON_COUNT-1:0] req_raw_levels,
   input  logic [TIME_W-1:0]       req_now_ms,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [BUTTON_COUNT-1:0] rsp_changed_mask,
   output logic [BUTTON_COUNT-1:0] rsp_down_mask,
   output logic [BUTTON_COUNT-1:0] rsp_pressed_mask,
   output logic [BUTTON_COUNT-1:0] rsp_long_press_mask,
   output logic                    rsp_any_change,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int RSP_W = 4 * BUTTON_COUNT + 1;
   localparam logic [BUTTON_COUNT-1:0] PRESENT_RST = BUTTON_COUNT'(3'b111);

   logic [MS_W-1:0]         debounce_ff, debounce_in;
   logic [MS_W-1:0]         hold_ff, hold_in;
   logic [BUTTON_COUNT-1:0] present_ff, present_in;

   logic                    accept;
   btn_res_type             res [BUTTON_COUNT];
   logic [BUTTON_COUNT-1:0] changed, down, long_press;
   logic [RSP_W-1:0]        rsp_data_in, rsp_data;

   always_comb begin
      debounce_in = debounce_ff;
      hold_in     = hold_ff;
      present_in  = present_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE: debounce_in = csr_wdata;
            CSR_HOLD:     hold_in     = csr_wdata;
            CSR_PRESENT:  present_in  = csr_wdata[BUTTON_COUNT-1:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RST;
         hold_ff     <= HOLD_RST;
         present_ff  <= PRESENT_RST;
      end else begin
         debounce_ff <= debounce_in;
         hold_ff     <= hold_in;
         present_ff  <= present_in;
      end
   end

   assign accept = req_valid && req_ready;

   for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_btn
      bdlp_button u_button (
         .clock       (clock),
         .reset       (reset),
         .sample_en   (accept),
         .present     (present_ff[i]),
         .level       (req_raw_levels[i]),
         .now_ms      (req_now_ms),
         .debounce_ms (debounce_ff),
         .hold_ms     (hold_ff),
         .res         (res[i])
      );
      assign changed[i]    = res[i].changed;
      assign down[i]       = res[i].down;
      assign long_press[i] = res[i].long_press;
   end

   // debounced state moves only where a changed bit is set
   assign rsp_data_in = {changed, down, changed & down, long_press, |changed};

   bdlp_rsp_reg #(
      .W (RSP_W)
   ) u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (rsp_data_in),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_changed_mask    = rsp_data[4*BUTTON_COUNT:3*BUTTON_COUNT+1];
   assign rsp_down_mask       = rsp_data[3*BUTTON_COUNT:2*BUTTON_COUNT+1];
   assign rsp_pressed_mask    = rsp_data[2*BUTTON_COUNT:BUTTON_COUNT+1];
   assign rsp_long_press_mask = rsp_data[BUTTON_COUNT:1];
   assign rsp_any_change      = rsp_data[0];

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted sample produced no response");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while a response is held");

   a_any_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_any_change == (rsp_changed_mask != '0)))
      else $error("any_change disagrees with changed mask");

   a_long_needs_down: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_long_press_mask & ~rsp_down_mask) == '0))
      else $error("long press on a button that is not down");

   a_one_shot: assert property (@(posedge clock) disable iff (reset)
      (accept && $past(accept) && $past(long_press) != '0 && ($past(down) & ~down) == '0
       && $past(req_raw_levels) == req_raw_levels && $stable(present_ff))
      |-> ((long_press & $past(long_press)) == '0))
      else $error("long press fired twice in one hold");

endmodule

// File: src/bdlp_button.sv
// per-button state: raw bit, change time, debounced bit and long-press-done bit
// depends on bdlp_pkg

module bdlp_button
   import bdlp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              sample_en,
   input  logic              present,
   input  logic              level,
   input  logic [TIME_W-1:0] now_ms,
   input  logic [MS_W-1:0]   debounce_ms,
   input  logic [MS_W-1:0]   hold_ms,
   output btn_res_type       res
);

   logic              raw_ff, raw_in;
   logic              deb_ff, deb_in;
   logic              long_ff, long_in;
   logic [TIME_W-1:0] time_ff, time_in;

   logic              sample;
   logic              raw_chg;
   logic              long_base;
   logic              deb_go;
   logic              long_go;
   logic [TIME_W-1:0] elapsed;

   always_comb begin
      sample    = present & ~level;
      raw_chg   = sample ^ raw_ff;
      raw_in    = sample;
      time_in   = raw_chg ? now_ms : time_ff;
      // a fresh raw change leaves zero elapsed time
      elapsed   = raw_chg ? '0 : (now_ms - time_ff);
      deb_go    = (raw_in ^ deb_ff) && (elapsed >= {{(TIME_W-MS_W){1'b0}}, debounce_ms});
      deb_in    = deb_go ? raw_in : deb_ff;
      // raw release clears the long-press flag
      long_base = (raw_chg && !sample) ? 1'b0 : long_ff;
      long_go   = deb_in && !long_base && (elapsed >= {{(TIME_W-MS_W){1'b0}}, hold_ms});
      long_in   = long_base | long_go;
      res.changed    = deb_go;
      res.down       = deb_in;
      res.long_press = long_go;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff  <= 1'b0;
         deb_ff  <= 1'b0;
         long_ff <= 1'b0;
         time_ff <= '0;
      end else if (sample_en) begin
         raw_ff  <= raw_in;
         deb_ff  <= deb_in;
         long_ff <= long_in;
         time_ff <= time_in;
      end
   end

endmodule

// File: src/bdlp_rsp_reg.sv
// result register between the sample logic and the response channel
// no dependencies

module bdlp_rsp_reg #(
   parameter int W = 13
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);

   logic         valid_ff, valid_in;
   logic [W-1:0] data_ff, data_in;

   always_comb begin
      in_ready = !valid_ff || out_ready;
      valid_in = in_ready ? in_valid : valid_ff;
      data_in  = (in_ready && in_valid) ? in_data : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
